FILE: rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/psp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package psp_pkg;

    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned SEED_W    = 30;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned CFG_IDX_W = 1;
    // The smallest prime above any count fits in one more bit than the count.
    localparam int unsigned PRIME_W   = COUNT_W + 1;
    // Trial divisors stay at or below the square root of the candidate.
    localparam int unsigned TRIAL_W   = (PRIME_W + 2) / 2;

    localparam int unsigned MAX_ELEMENTS_DEFAULT = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_SEED     = 1'b1;

    typedef struct packed {
        logic accept;
        logic cand_init;
        logic cand_next;
        logic trial_start;
        logic seed_start;
        logic next_divisor;
        logic skip_load;
        logic step;
        logic out_load;
    } psp_cmd_t;

    typedef struct packed {
        logic prepared;
        logic sqr_over;
        logic div_done;
        logic div_zero;
        logic visits_done;
        logic step_hit;
    } psp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/psp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [psp_pkg::SEED_W-1:0]   dividend,
    input  wire logic [psp_pkg::PRIME_W-1:0]  divisor,
    output logic                              done,
    output logic [psp_pkg::PRIME_W-1:0]       remainder
);
    import psp_pkg::*;

    localparam int unsigned CNT_W = $clog2(SEED_W + 1);

    logic [PRIME_W-1:0] rem_reg, rem_next;
    logic [SEED_W-1:0]  dvd_reg, dvd_next;
    logic [PRIME_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [PRIME_W:0]   shifted;
    logic [PRIME_W:0]   reduced;

    // One quotient bit per cycle, restoring form; only the remainder is kept.
    assign shifted = {rem_reg, dvd_reg[SEED_W-1]};
    assign reduced = (shifted >= {1'b0, dvs_reg}) ? shifted - {1'b0, dvs_reg} : shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(SEED_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = reduced[PRIME_W-1:0];
            dvd_next = {dvd_reg[SEED_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/psp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_datapath #(
    parameter int unsigned MAX_ELEMENTS = psp_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psp_pkg::SEED_W-1:0]     cfg_data,
    input  wire logic                           restart,
    input  wire psp_pkg::psp_cmd_t              cmd,
    output psp_pkg::psp_stat_t                  stat,
    output logic [psp_pkg::INDEX_W-1:0]         index,
    output logic                                exhausted
);
    import psp_pkg::*;

    localparam int unsigned COUNT_LIMIT = (1 << COUNT_W) - 1;
    localparam int unsigned CAP = (MAX_ELEMENTS < COUNT_LIMIT) ? MAX_ELEMENTS : COUNT_LIMIT;
    localparam logic [COUNT_W-1:0] CAP_V = COUNT_W'(CAP);

    logic [COUNT_W-1:0] element_count_reg, element_count_next;
    logic [SEED_W-1:0]  skip_seed_reg, skip_seed_next;
    logic               prepared_reg, prepared_next;
    logic [PRIME_W-1:0] position_reg, position_next;
    logic [PRIME_W-1:0] visit_reg, visit_next;
    logic [PRIME_W-1:0] prime_reg, prime_next;
    logic [PRIME_W-1:0] skip_reg, skip_next;
    logic [PRIME_W-1:0] cand_reg, cand_next;
    logic [TRIAL_W-1:0] trial_reg, trial_next;
    logic [INDEX_W-1:0] res_index_reg, res_index_next;
    logic               res_exh_reg, res_exh_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic               exhausted_reg, exhausted_next;

    logic [COUNT_W-1:0]   eff_count;
    logic [2*TRIAL_W-1:0] trial_sq;
    logic [PRIME_W:0]     step_sum;
    logic [PRIME_W-1:0]   step_pos;
    logic                 step_hit;
    logic                 visits_done;
    logic                 div_start;
    logic                 div_done;
    logic [SEED_W-1:0]    div_dividend;
    logic [PRIME_W-1:0]   div_divisor;
    logic [PRIME_W-1:0]   div_rem;

    always_comb
    begin
        if (element_count_reg == '0)
            eff_count = COUNT_W'(1);
        else if (element_count_reg > CAP_V)
            eff_count = CAP_V;
        else
            eff_count = element_count_reg;
    end

    assign trial_sq    = trial_reg * trial_reg;
    assign step_sum    = {1'b0, position_reg} + {1'b0, skip_reg};
    assign step_pos    = (step_sum >= {1'b0, prime_reg})
                       ? PRIME_W'(step_sum - {1'b0, prime_reg})
                       : step_sum[PRIME_W-1:0];
    assign step_hit    = step_pos < {1'b0, eff_count};
    assign visits_done = visit_reg >= prime_reg;

    assign div_start    = cmd.trial_start || cmd.seed_start;
    assign div_dividend = cmd.seed_start ? skip_seed_reg : SEED_W'(cand_reg);
    assign div_divisor  = cmd.seed_start ? cand_reg : PRIME_W'(trial_reg);

    psp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_comb
    begin
        element_count_next = element_count_reg;
        skip_seed_next     = skip_seed_reg;
        prepared_next      = prepared_reg;
        position_next      = position_reg;
        visit_next         = visit_reg;
        prime_next         = prime_reg;
        skip_next          = skip_reg;
        cand_next          = cand_reg;
        trial_next         = trial_reg;
        res_index_next     = res_index_reg;
        res_exh_next       = res_exh_reg;
        index_next         = index_reg;
        exhausted_next     = exhausted_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ELEMENT_COUNT: element_count_next = cfg_data[COUNT_W-1:0];
                REG_SKIP_SEED:     skip_seed_next = cfg_data;
                default:           skip_seed_next = skip_seed_reg;
            endcase
            prepared_next = 1'b0;
            position_next = '0;
            visit_next    = '0;
        end

        if (cmd.accept && restart)
        begin
            position_next = '0;
            visit_next    = '0;
        end

        if (cmd.cand_init)
            cand_next = PRIME_W'(eff_count);

        if (cmd.cand_next)
        begin
            cand_next  = cand_reg + PRIME_W'(1);
            trial_next = TRIAL_W'(2);
        end

        if (cmd.next_divisor)
            trial_next = trial_reg + TRIAL_W'(1);

        if (cmd.seed_start)
            prime_next = cand_reg;

        if (cmd.skip_load)
        begin
            skip_next     = (div_rem == '0) ? PRIME_W'(1) : div_rem;
            prepared_next = 1'b1;
        end

        if (cmd.step)
        begin
            if (visits_done)
            begin
                res_index_next = '0;
                res_exh_next   = 1'b1;
            end
            else
            begin
                position_next  = step_pos;
                visit_next     = visit_reg + PRIME_W'(1);
                res_index_next = step_pos[INDEX_W-1:0];
                res_exh_next   = 1'b0;
            end
        end

        if (cmd.out_load)
        begin
            index_next     = res_index_reg;
            exhausted_next = res_exh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= COUNT_W'(1);
            skip_seed_reg     <= SEED_W'(1);
            prepared_reg      <= 1'b0;
            position_reg      <= '0;
            visit_reg         <= '0;
        end
        else
        begin
            element_count_reg <= element_count_next;
            skip_seed_reg     <= skip_seed_next;
            prepared_reg      <= prepared_next;
            position_reg      <= position_next;
            visit_reg         <= visit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prime_reg     <= prime_next;
        skip_reg      <= skip_next;
        cand_reg      <= cand_next;
        trial_reg     <= trial_next;
        res_index_reg <= res_index_next;
        res_exh_reg   <= res_exh_next;
        index_reg     <= index_next;
        exhausted_reg <= exhausted_next;
    end

    always_comb
    begin
        stat.prepared    = prepared_reg;
        stat.sqr_over    = trial_sq > (2*TRIAL_W)'(cand_reg);
        stat.div_done    = div_done;
        stat.div_zero    = div_rem == '0;
        stat.visits_done = visits_done;
        stat.step_hit    = step_hit;
    end

    assign index     = index_reg;
    assign exhausted = exhausted_reg;

endmodule

`default_nettype wire

FILE: rtl/psp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module psp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               out_stall,
    input  wire psp_pkg::psp_stat_t stat,
    output psp_pkg::psp_cmd_t       cmd,
    output logic                    in_stall,
    output logic                    out_valid,
    output logic                    cfg_ready
);
    import psp_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        PREP_INIT,
        NEXT_CAND,
        TEST,
        DIV_WAIT,
        SEED_WAIT,
        STEP,
        RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd              = '0;
        cmd.accept       = (state_reg == IDLE) && in_valid;
        cmd.cand_init    = state_reg == PREP_INIT;
        cmd.cand_next    = state_reg == NEXT_CAND;
        cmd.trial_start  = (state_reg == TEST) && !stat.sqr_over;
        cmd.seed_start   = (state_reg == TEST) && stat.sqr_over;
        cmd.next_divisor = (state_reg == DIV_WAIT) && stat.div_done && !stat.div_zero;
        cmd.skip_load    = (state_reg == SEED_WAIT) && stat.div_done;
        cmd.step         = state_reg == STEP;
        cmd.out_load     = (state_reg == RESULT) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                    state_next = stat.prepared ? STEP : PREP_INIT;
            end
            PREP_INIT: state_next = NEXT_CAND;
            NEXT_CAND: state_next = TEST;
            TEST:      state_next = stat.sqr_over ? SEED_WAIT : DIV_WAIT;
            DIV_WAIT:
            begin
                if (stat.div_done)
                    state_next = stat.div_zero ? NEXT_CAND : TEST;
            end
            SEED_WAIT:
            begin
                if (stat.div_done)
                    state_next = STEP;
            end
            STEP:
            begin
                if (stat.visits_done || stat.step_hit)
                    state_next = RESULT;
            end
            RESULT:
            begin
                if (out_free)
                begin
                    state_next     = IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An offered item takes precedence over a register write in the same cycle.
    assign in_stall  = state_reg != IDLE;
    assign cfg_ready = (state_reg == IDLE) && !in_valid;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/prime_skip_permutation.sv
`timescale 1ns / 1ps
`default_nettype none

// Returns each index below element_count (zero counting as one, capped at
// MAX_ELEMENTS) exactly once in a pseudo-random order, one index per item; after all
// positions of the prime cycle are used, each further item returns index 0 with
// exhausted set until an item with restart arrives. An ordinary item steps the
// position adder, which visits one position per cycle, past k out-of-range positions;
// k averages about (prime - count) / count, at most one. The first item after reset
// or after any register write also prepares the block: it searches the smallest
// prime above the count by trial division through a shared remainder unit, one
// divisor per division, then reduces skip_seed through the same unit. Registers are
// written only while no item is in progress and no item is offered.
module prime_skip_permutation #(
    parameter int unsigned MAX_ELEMENTS = psp_pkg::MAX_ELEMENTS_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           restart,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [psp_pkg::INDEX_W-1:0]         index,
    output logic                                exhausted,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psp_pkg::SEED_W-1:0]     cfg_data
);
    import psp_pkg::*;

    psp_cmd_t  cmd;
    psp_stat_t stat;
    logic      cfg_we;

    assign cfg_we = cfg_valid && cfg_ready;

    psp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cfg_ready (cfg_ready)
    );

    psp_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .restart   (restart),
        .cmd       (cmd),
        .stat      (stat),
        .index     (index),
        .exhausted (exhausted)
    );

endmodule

`default_nettype wire

FILE: rtl/psp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psp_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [psp_pkg::INDEX_W-1:0]    index,
    input wire logic                           exhausted,
    input wire logic                           cfg_ready
);
    import psp_pkg::*;

    `ASSERT_SAME(a_exhausted_index_zero, clk, rst_n, out_valid && exhausted, index == '0)
    `ASSERT_NEXT(a_held_result, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(index) && $stable(exhausted))
    `ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(in_stall))
    `ASSERT_SAME(a_cfg_only_idle, clk, rst_n, cfg_ready, !in_stall)

endmodule

bind prime_skip_permutation psp_checker u_psp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .index     (index),
    .exhausted (exhausted),
    .cfg_ready (cfg_ready)
);

`default_nettype wire

FILE: sim/prime_skip_permutation_tb.sv
`timescale 1ns / 1ps

module prime_skip_permutation_tb;
    import psp_pkg::*;

    localparam int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEFAULT;
    localparam int STALL_PCT = 38;
    localparam int RANDOM_ITEMS = 1100;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 64;

    class perm_checker;
        typedef struct packed {
            logic [INDEX_W-1:0] idx;
            logic               done;
        } perm_result_t;

        perm_result_t        expected_indices[$];
        logic [COUNT_W-1:0]  count_reg;
        logic [SEED_W-1:0]   seed_reg;
        logic [COUNT_W-1:0]  position;
        logic [COUNT_W-1:0]  visits;
        logic [COUNT_W-1:0]  modulus;
        logic [COUNT_W-1:0]  skip;
        bit                  ready;
        int                  errors;
        int                  requests;
        int                  checked;
        int                  exhausted_seen;

        function new();
            count_reg = 1;
            seed_reg = 1;
            position = 0;
            visits = 0;
            modulus = 0;
            skip = 0;
            ready = 0;
            errors = 0;
            requests = 0;
            checked = 0;
            exhausted_seen = 0;
        endfunction

        function int unsigned clamped_count();
            int unsigned c;
            c = count_reg;
            if (c == 0)
                c = 1;
            if (c > MAX_ELEMENTS)
                c = MAX_ELEMENTS;
            return c;
        endfunction

        function bit is_prime(int unsigned v);
            int unsigned d;
            if (v <= 1)
                return 0;
            if (v <= 3)
                return 1;
            if (v % 2 == 0 || v % 3 == 0)
                return 0;
            for (d = 5; d * d <= v; d += 6)
                if (v % d == 0 || v % (d + 2) == 0)
                    return 0;
            return 1;
        endfunction

        function void find_prime_and_skip();
            int unsigned p;
            int unsigned s;
            p = clamped_count();
            do
                p++;
            while (!is_prime(p));
            s = seed_reg % p;
            if (s == 0)
                s = 1;
            modulus = COUNT_W'(p);
            skip = COUNT_W'(s);
            ready = 1;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] which, logic [SEED_W-1:0] data);
            if (which == REG_ELEMENT_COUNT)
                count_reg = data[COUNT_W-1:0];
            else
                seed_reg = data;
            ready = 0;
            position = 0;
            visits = 0;
        endfunction

        function void note_request(bit restart_req);
            int unsigned cnt;
            int unsigned next_pos;
            perm_result_t r;
            bit found;
            requests++;
            if (!ready)
                find_prime_and_skip();
            if (restart_req)
            begin
                position = 0;
                visits = 0;
            end
            cnt = clamped_count();
            found = 0;
            while (!found)
            begin
                if (visits >= modulus)
                begin
                    r.idx = '0;
                    r.done = 1'b1;
                    found = 1;
                end
                else
                begin
                    next_pos = (int'(position) + int'(skip)) % int'(modulus);
                    position = COUNT_W'(next_pos);
                    visits = visits + 1'b1;
                    if (next_pos < cnt)
                    begin
                        r.idx = INDEX_W'(next_pos);
                        r.done = 1'b0;
                        found = 1;
                    end
                end
            end
            expected_indices.push_back(r);
        endfunction

        function void check_index(logic [INDEX_W-1:0] idx, logic done);
            perm_result_t e;
            if (expected_indices.size() == 0)
            begin
                $error("unexpected item: index %0d exhausted %0b", idx, done);
                errors++;
                return;
            end
            e = expected_indices.pop_front();
            checked++;
            if (e.done)
                exhausted_seen++;
            if (idx !== e.idx)
            begin
                $error("index: expected %0d, actual %0d", e.idx, idx);
                errors++;
            end
            if (done !== e.done)
            begin
                $error("exhausted: expected %0b, actual %0b", e.done, done);
                errors++;
            end
        endfunction

        function int pending();
            return expected_indices.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 restart = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [INDEX_W-1:0]   index;
    logic                 exhausted;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SEED_W-1:0]    cfg_data = '0;

    perm_checker chk = new();
    bit steady = 0;
    int idle_cycles = 0;
    int settings = 0;

    prime_skip_permutation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .restart   (restart),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .index     (index),
        .exhausted (exhausted),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !steady && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            chk.check_index(index, exhausted);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input bit r);
        in_valid <= 1'b1;
        restart <= r;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        chk.note_request(r);
        while (!steady && $urandom_range(99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_results();
        if (chk.pending() != 0)
        begin
            in_valid <= 1'b0;
            while (chk.pending() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [SEED_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        chk.note_config(which, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input bit wr_count, input logic [SEED_W-1:0] count_data,
                             input bit wr_seed, input logic [SEED_W-1:0] seed_data);
        in_valid <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        if (wr_count)
            write_reg(REG_ELEMENT_COUNT, count_data);
        if (wr_seed)
            write_reg(REG_SKIP_SEED, seed_data);
        settings++;
    endtask

    initial
    begin
        int phase;
        int n_items;
        int r;
        int unsigned cnt;
        int unsigned eff;
        logic [SEED_W-1:0] cdata;
        logic [SEED_W-1:0] sdata;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one element, prime two; run past exhaustion and restart.
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        // Two elements with a zero seed, so the skip falls back to one.
        configure(1, 30'd2, 1, 30'd0);
        repeat (4) send_item(1'b0);
        // A zero count behaves as one element.
        configure(1, 30'd0, 1, 30'd3);
        repeat (3) send_item(1'b0);
        // All ones: the count saturates and the seed is at its maximum.
        configure(1, 30'h3FFF_FFFF, 1, 30'h3FFF_FFFF);
        repeat (3) send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        // The seed is a multiple of the prime.
        configure(1, 30'd4, 1, 30'd10);
        repeat (6) send_item(1'b0);
        send_item(1'b1);

        eff = 4;
        phase = 0;
        while (chk.requests < RANDOM_ITEMS + 24)
        begin
            steady = (phase >= 15 && phase < 22);
            r = $urandom_range(99);
            if (r < 70)
                cnt = $urandom_range(1, 40);
            else if (r < 92)
                cnt = $urandom_range(41, 400);
            else if (r < 97)
                cnt = $urandom_range(0, 131071);
            else
                cnt = $urandom_range(65500, 65536);
            cdata = {($urandom_range(1) != 0) ? 13'($urandom()) : 13'd0, 17'(cnt)};
            r = $urandom_range(99);
            if (r < 10)
                sdata = '0;
            else if (r < 20)
                sdata = '1;
            else if (r < 35)
                sdata = SEED_W'($urandom_range(0, 100));
            else
                sdata = SEED_W'($urandom());
            r = (phase == 0) ? 2 : $urandom_range(2);
            configure(r != 1, cdata, r != 0, sdata);
            if (r != 1)
                eff = (cnt == 0) ? 1 : (cnt > MAX_ELEMENTS) ? MAX_ELEMENTS : cnt;
            n_items = (eff <= 60) ? int'(eff) + $urandom_range(1, 6) : $urandom_range(20, 120);
            repeat (n_items)
            begin
                send_item($urandom_range(99) < 3);
                if ($urandom_range(99) < 4)
                    wait_results();
            end
            phase++;
        end

        in_valid <= 1'b0;
        steady = 0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items across %0d register settings; %0d results checked.",
                 chk.requests, settings, chk.checked);
        $display("%0d results reported an exhausted permutation.", chk.exhausted_seen);
        if (chk.errors == 0 && chk.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: prime_skip_permutation.f
+incdir+rtl
rtl/psp_pkg.sv
rtl/psp_div.sv
rtl/psp_datapath.sv
rtl/psp_ctrl.sv
rtl/prime_skip_permutation.sv
rtl/psp_checker.sv
sim/prime_skip_permutation_tb.sv
